// File: rtl/core/fsps_pkg.sv
package fsps_pkg;

  localparam int PHASE_BITS_DEFAULT = 16;
  localparam int PIXEL_BITS_DEFAULT = 8;

  localparam int THRESHOLD_WIDTH = 9;
  typedef logic [THRESHOLD_WIDTH-1:0] threshold_t;
  localparam threshold_t THRESHOLD_RESET = 9'd3;

  // Vectors are scaled up before the rotations so that the shifted terms keep their bits.
  localparam int PRESCALE_BITS = 40;
  localparam int CORDIC_STEPS = 30;

  // Angles are held in units of 2^-32 turn and wrap modulo one turn.
  localparam int ANGLE_BITS = 32;
  typedef logic [ANGLE_BITS-1:0] angle_t;
  localparam angle_t ANGLE_HALF_TURN = 32'h8000_0000;

  localparam angle_t ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

endpackage

// File: rtl/core/fsps_prep.sv
module fsps_prep #(
  parameter int PIXEL_BITS = fsps_pkg::PIXEL_BITS_DEFAULT,
  parameter int XY_BITS = fsps_pkg::PIXEL_BITS_DEFAULT + fsps_pkg::PRESCALE_BITS + 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [PIXEL_BITS-1:0]         intensity_a,
  input  logic [PIXEL_BITS-1:0]         intensity_b,
  input  logic [PIXEL_BITS-1:0]         intensity_c,
  input  logic [PIXEL_BITS-1:0]         intensity_d,
  output logic signed [PIXEL_BITS:0]    num,
  output logic signed [PIXEL_BITS:0]    den,
  output logic                          xy_valid,
  output logic signed [XY_BITS-1:0]     x,
  output logic signed [XY_BITS-1:0]     y,
  output fsps_pkg::angle_t              z
);

  logic                       diff_valid;
  logic signed [XY_BITS-1:0]  num_ext;
  logic signed [XY_BITS-1:0]  den_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      xy_valid <= 1'b0;
    end else begin
      diff_valid <= in_valid;
      xy_valid <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    num <= $signed({1'b0, intensity_d}) - $signed({1'b0, intensity_b});
    den <= $signed({1'b0, intensity_c}) - $signed({1'b0, intensity_a});
  end

  assign num_ext = {{(XY_BITS-PIXEL_BITS-1){num[PIXEL_BITS]}}, num} <<< fsps_pkg::PRESCALE_BITS;
  assign den_ext = {{(XY_BITS-PIXEL_BITS-1){den[PIXEL_BITS]}}, den} <<< fsps_pkg::PRESCALE_BITS;

  // A vector in the left half plane is turned by half a turn first.
  always_ff @(posedge clk) begin
    if (den[PIXEL_BITS]) begin
      x <= -den_ext;
      y <= -num_ext;
      z <= fsps_pkg::ANGLE_HALF_TURN;
    end else begin
      x <= den_ext;
      y <= num_ext;
      z <= '0;
    end
  end

endmodule

// File: rtl/core/fsps_cordic_stage.sv
module fsps_cordic_stage #(
  parameter int XY_BITS = fsps_pkg::PIXEL_BITS_DEFAULT + fsps_pkg::PRESCALE_BITS + 4,
  parameter int STEP = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [XY_BITS-1:0] in_x,
  input  logic signed [XY_BITS-1:0] in_y,
  input  fsps_pkg::angle_t          in_z,
  output logic                      out_valid,
  output logic signed [XY_BITS-1:0] out_x,
  output logic signed [XY_BITS-1:0] out_y,
  output fsps_pkg::angle_t          out_z
);

  logic signed [XY_BITS-1:0] x_shift;
  logic signed [XY_BITS-1:0] y_shift;

  assign x_shift = in_x >>> STEP;
  assign y_shift = in_y >>> STEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_y[XY_BITS-1]) begin
      out_x <= in_x + y_shift;
      out_y <= in_y - x_shift;
      out_z <= in_z + fsps_pkg::ATAN_TURNS[STEP];
    end else begin
      out_x <= in_x - y_shift;
      out_y <= in_y + x_shift;
      out_z <= in_z - fsps_pkg::ATAN_TURNS[STEP];
    end
  end

endmodule

// File: rtl/core/fsps_modcheck.sv
module fsps_modcheck #(
  parameter int PIXEL_BITS = fsps_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                       clk,
  input  fsps_pkg::threshold_t       threshold,
  input  logic signed [PIXEL_BITS:0] num,
  input  logic signed [PIXEL_BITS:0] den,
  output logic                       ok
);

  localparam int THR_SQ_BITS = 2 * fsps_pkg::THRESHOLD_WIDTH;
  localparam int CMP_BITS = (2 * PIXEL_BITS + 1 > THR_SQ_BITS) ? 2 * PIXEL_BITS + 1 : THR_SQ_BITS;
  // The delay line brings the compare result to the rounding stage together with the rotated angle.
  localparam int DELAY = fsps_pkg::CORDIC_STEPS - 1;

  logic signed [2*PIXEL_BITS+1:0] num_prod;
  logic signed [2*PIXEL_BITS+1:0] den_prod;
  logic [2*PIXEL_BITS-1:0]        num_sq;
  logic [2*PIXEL_BITS-1:0]        den_sq;
  logic [THR_SQ_BITS-1:0]         thr_sq;
  logic [CMP_BITS-1:0]            mag_sq;
  logic                           ok_early;
  logic                           ok_line [DELAY];

  assign num_prod = num * num;
  assign den_prod = den * den;

  always_ff @(posedge clk) begin
    num_sq <= num_prod[2*PIXEL_BITS-1:0];
    den_sq <= den_prod[2*PIXEL_BITS-1:0];
    thr_sq <= THR_SQ_BITS'(threshold) * THR_SQ_BITS'(threshold);
  end

  assign mag_sq = CMP_BITS'(num_sq) + CMP_BITS'(den_sq);

  always_ff @(posedge clk) begin
    ok_early <= mag_sq > CMP_BITS'(thr_sq);
    ok_line[0] <= ok_early;
    for (int k = 1; k < DELAY; k++) begin
      ok_line[k] <= ok_line[k-1];
    end
  end

  assign ok = ok_line[DELAY-1];

endmodule

// File: rtl/core/fsps_round.sv
module fsps_round #(
  parameter int PHASE_BITS = fsps_pkg::PHASE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  fsps_pkg::angle_t      angle,
  input  logic                  ok,
  output logic                  done,
  output logic [PHASE_BITS-1:0] wrapped_phase,
  output logic                  modulation_ok
);

  localparam fsps_pkg::angle_t ROUND_BIAS =
    fsps_pkg::angle_t'(1) << (fsps_pkg::ANGLE_BITS - 1 - PHASE_BITS);

  fsps_pkg::angle_t biased;

  assign biased = angle + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    modulation_ok <= ok;
    if (ok) begin
      wrapped_phase <= biased[fsps_pkg::ANGLE_BITS-1 -: PHASE_BITS];
    end else begin
      wrapped_phase <= '0;
    end
  end

endmodule

// File: rtl/core/four_step_phase_shift_pixel_core.sv
// Wrapped phase of one pixel from four phase-shifted pattern intensities.
// An item is the four intensities of one pixel. It is accepted at a rising edge of clk
// at which start is high and busy is low; busy never rises, so one item can enter in
// every cycle.
// Each result is shown for exactly one cycle with done high: wrapped_phase is the angle
// of (d - b, c - a) as a fraction of a full turn, and modulation_ok tells whether the
// modulation strictly exceeds the threshold. A masked pixel gives a phase of zero.
// The differences are registered, the vector is turned into the right half plane and
// registered, it passes the 30 registered rotation stages, and a last register rounds
// and gates the result. Throughput is one item per cycle, set by the rotation
// pipeline. The threshold is loaded by modulation_threshold_we with the value on
// modulation_threshold, and should be changed only while no item is in flight.
// A synchronous reset on rst empties the pipeline and sets the threshold to 3.
// The receiver cannot stall, so results leave at the rate items entered.
module four_step_phase_shift_pixel_core #(
  parameter int PHASE_BITS = fsps_pkg::PHASE_BITS_DEFAULT,
  parameter int PIXEL_BITS = fsps_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [PIXEL_BITS-1:0] intensity_a,
  input  logic [PIXEL_BITS-1:0] intensity_b,
  input  logic [PIXEL_BITS-1:0] intensity_c,
  input  logic [PIXEL_BITS-1:0] intensity_d,
  input  logic                  modulation_threshold_we,
  input  fsps_pkg::threshold_t  modulation_threshold,
  output logic                  done,
  output logic [PHASE_BITS-1:0] wrapped_phase,
  output logic                  modulation_ok
);

  localparam int XY_BITS = PIXEL_BITS + fsps_pkg::PRESCALE_BITS + 4;
  localparam int STEPS = fsps_pkg::CORDIC_STEPS;
  localparam int LATENCY = STEPS + 3;

  fsps_pkg::threshold_t        threshold;
  logic signed [PIXEL_BITS:0]  num;
  logic signed [PIXEL_BITS:0]  den;
  logic                        ok;
  logic                        valid_pipe [STEPS+1];
  logic signed [XY_BITS-1:0]   x_pipe [STEPS+1];
  logic signed [XY_BITS-1:0]   y_pipe [STEPS+1];
  fsps_pkg::angle_t            z_pipe [STEPS+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= fsps_pkg::THRESHOLD_RESET;
    end else if (modulation_threshold_we) begin
      threshold <= modulation_threshold;
    end
  end

  fsps_prep #(
    .PIXEL_BITS(PIXEL_BITS),
    .XY_BITS(XY_BITS)
  ) u_prep (
    .clk(clk),
    .rst(rst),
    .in_valid(start && !busy),
    .intensity_a(intensity_a),
    .intensity_b(intensity_b),
    .intensity_c(intensity_c),
    .intensity_d(intensity_d),
    .num(num),
    .den(den),
    .xy_valid(valid_pipe[0]),
    .x(x_pipe[0]),
    .y(y_pipe[0]),
    .z(z_pipe[0])
  );

  fsps_modcheck #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_modcheck (
    .clk(clk),
    .threshold(threshold),
    .num(num),
    .den(den),
    .ok(ok)
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    fsps_cordic_stage #(
      .XY_BITS(XY_BITS),
      .STEP(i)
    ) u_stage (
      .clk(clk),
      .rst(rst),
      .in_valid(valid_pipe[i]),
      .in_x(x_pipe[i]),
      .in_y(y_pipe[i]),
      .in_z(z_pipe[i]),
      .out_valid(valid_pipe[i+1]),
      .out_x(x_pipe[i+1]),
      .out_y(y_pipe[i+1]),
      .out_z(z_pipe[i+1])
    );
  end

  fsps_round #(
    .PHASE_BITS(PHASE_BITS)
  ) u_round (
    .clk(clk),
    .rst(rst),
    .in_valid(valid_pipe[STEPS]),
    .angle(z_pipe[STEPS]),
    .ok(ok),
    .done(done),
    .wrapped_phase(wrapped_phase),
    .modulation_ok(modulation_ok)
  );

  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("accepted item produced no result");

  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without an accepted item");

  a_masked_phase_zero: assert property (@(posedge clk) disable iff (rst)
    done && !modulation_ok |-> wrapped_phase == '0)
    else $error("masked pixel carries a nonzero phase");

  a_flat_pixel_masked: assert property (@(posedge clk) disable iff (rst)
    start && intensity_a == intensity_c && intensity_b == intensity_d
      |-> ##LATENCY !modulation_ok)
    else $error("pixel without modulation passed the threshold");

endmodule
